// ===== hdl/ksd_pkg.sv =====
// ----------------------------------------------------------------------------
// ksd_pkg
// Shared codes and types for the key sequence detector.
// ----------------------------------------------------------------------------
package ksd_pkg;

  localparam int SEQ_SLOTS  = 4;
  localparam int SYM_BITS   = 8;
  localparam int ROW_BITS   = 64;
  localparam int ADDR_BITS  = 6;
  localparam int DATA_BITS  = 64;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_TICK     = 2'd0;
  localparam mode_t MODE_POLL     = 2'd1;
  localparam mode_t MODE_POLL_KEY = 2'd2;
  localparam mode_t MODE_NONE     = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_NONE     = 2'd0;
  localparam status_t STATUS_PROGRESS = 2'd1;
  localparam status_t STATUS_DONE     = 2'd2;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_SEQ0    = 3'd0;
  localparam reg_idx_t REG_SEQ1    = 3'd1;
  localparam reg_idx_t REG_SEQ2    = 3'd2;
  localparam reg_idx_t REG_SEQ3    = 3'd3;
  localparam reg_idx_t REG_LENGTHS = 3'd4;
  localparam reg_idx_t REG_ENABLES = 3'd5;
  localparam reg_idx_t REG_TIMEOUT = 3'd6;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] TICK_MAX      = 16'hFFFF;

  typedef struct packed {
    status_t    status;
    logic [1:0] seq_index;
    logic       key_taken;
  } result_t;

endpackage

// ===== hdl/key_sequence_detector_top.sv =====
// ----------------------------------------------------------------------------
// key_sequence_detector_top
// Watches key scancodes for one of four stored, enabled symbol sequences.
//
// Input channel (in_valid/in_stall): in_mode selects a timer tick, a poll
// without a key or a poll with in_key_code. A tick gives no result; every
// poll gives one result on the output channel (out_valid/out_stall) with
// out_status, out_seq_index and out_key_taken.
// A tick or an ignored mode leaves the block in ST_IDLE. A poll passes
// through ST_EMIT to the output register: straight from ST_IDLE when
// idle without a key, via ST_CUR when tracking, and via ST_SCAN when
// stored sequences are searched. The search compares one stored sequence
// per cycle in a single comparator, and in_stall stays high until the
// poll's result is in the output register.
// The output register holds a result while out_stall is high; the next
// input may be taken meanwhile, and its result waits until the register
// frees up.
// Reset (rst_n low, synchronous) clears tracking, position, timer,
// sequences, lengths and enables, and sets the timeout to 1000 ticks.
// Registers sit on the cfg_ APB port, 64 bits each, at 8 * index.
// ----------------------------------------------------------------------------
module key_sequence_detector_top #(
  parameter int NUM_SEQS = 4,
  parameter int MAX_LEN  = 8,
  parameter int KEY_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ksd_pkg::mode_t             in_mode,
  input  logic [7:0]                 in_key_code,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ksd_pkg::status_t           out_status,
  output logic [1:0]                 out_seq_index,
  output logic                       out_key_taken,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ksd_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  logic [ksd_pkg::DATA_BITS-1:0] cfg_pwdata,
  output logic [ksd_pkg::DATA_BITS-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import ksd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CUR  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [1:0] SCAN_LAST = 2'(NUM_SEQS - 1);
  localparam logic [7:0] KEY_MASK  = 8'((1 << KEY_BITS) - 1);

  function automatic logic [7:0] sym_byte(logic [ROW_BITS-1:0] row, logic [2:0] k);
    return row[{k, 3'b000} +: SYM_BITS];
  endfunction

  function automatic logic [3:0] len_of(logic [15:0] lens, logic [1:0] n);
    logic [3:0] l;
    l = lens[{n, 2'b00} +: 4];
    return (l > 4'(MAX_LEN)) ? 4'(MAX_LEN) : l;
  endfunction

  // configuration
  logic [ROW_BITS-1:0] sym_r [SEQ_SLOTS];
  logic [15:0]         lengths_r;
  logic [3:0]          enables_r;
  logic [15:0]         timeout_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  // sequencer
  logic [1:0]          state_r, state_nxt;
  logic                tracking_r, tracking_nxt;
  logic [1:0]          cur_seq_r, cur_seq_nxt;
  logic [3:0]          pos_r, pos_nxt;
  logic [15:0]         tick_r, tick_nxt;
  logic [7:0]          key_r, key_nxt;
  logic                has_key_r, has_key_nxt;
  logic                start_r, start_nxt;
  logic [ROW_BITS-1:0] cur_row_r, cur_row_nxt;
  logic [1:0]          scan_r, scan_nxt;
  result_t             res_r, res_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  result_t             out_res_r;
  logic                out_load;

  // shared compare unit
  logic [ROW_BITS-1:0] row_sel;
  logic [1:0]          row_idx;
  logic [3:0]          len_sel;
  logic [ROW_BITS-1:0] pfx_mask;
  logic                pfx_eq;
  logic                hit;
  logic                in_xfer;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[ADDR_BITS-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < SEQ_SLOTS; n++) begin
        sym_r[n] <= '0;
      end
      lengths_r <= '0;
      enables_r <= '0;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SEQ0, REG_SEQ1, REG_SEQ2, REG_SEQ3: sym_r[cfg_idx[1:0]] <= cfg_pwdata;
        REG_LENGTHS: lengths_r <= cfg_pwdata[15:0];
        REG_ENABLES: enables_r <= cfg_pwdata[3:0];
        REG_TIMEOUT: timeout_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SEQ0, REG_SEQ1, REG_SEQ2, REG_SEQ3: cfg_prdata = sym_r[cfg_idx[1:0]];
      REG_LENGTHS: cfg_prdata = {48'd0, lengths_r};
      REG_ENABLES: cfg_prdata = {60'd0, enables_r};
      REG_TIMEOUT: cfg_prdata = {48'd0, timeout_r};
      default:     cfg_prdata = '0;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid & ~in_stall;
  assign out_load = (state_r == ST_EMIT) & (~out_valid_r | ~out_stall);

  // one stored row read per cycle: current sequence in ST_CUR, scan slot else
  assign row_idx  = (state_r == ST_SCAN) ? scan_r : cur_seq_r;
  assign row_sel  = sym_r[row_idx];
  assign len_sel  = len_of(lengths_r, row_idx);
  assign pfx_mask = ~({ROW_BITS{1'b1}} << {pos_r[2:0], 3'b000});
  assign pfx_eq   = ((row_sel ^ cur_row_r) & pfx_mask) == '0;

  always_comb begin
    if (start_r) begin
      hit = enables_r[scan_r] && (len_sel != 4'd0) && (sym_byte(row_sel, 3'd0) == key_r);
    end else begin
      hit = enables_r[scan_r] && (scan_r != cur_seq_r) && (pos_r < len_sel) && pfx_eq &&
            (sym_byte(row_sel, pos_r[2:0]) == key_r);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    tracking_nxt = tracking_r;
    cur_seq_nxt  = cur_seq_r;
    pos_nxt      = pos_r;
    tick_nxt     = tick_r;
    key_nxt      = key_r;
    has_key_nxt  = has_key_r;
    start_nxt    = start_r;
    cur_row_nxt  = cur_row_r;
    scan_nxt     = scan_r;
    res_nxt      = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          key_nxt     = in_key_code & KEY_MASK;
          has_key_nxt = (in_mode == MODE_POLL_KEY);
          res_nxt     = '{status: STATUS_NONE, seq_index: 2'd0, key_taken: 1'b0};
          unique case (in_mode)
            MODE_TICK: begin
              if (tick_r != TICK_MAX) begin
                tick_nxt = tick_r + 16'd1;
              end
            end
            MODE_POLL, MODE_POLL_KEY: begin
              if (tracking_r) begin
                state_nxt = ST_CUR;
              end else if (in_mode == MODE_POLL_KEY) begin
                start_nxt = 1'b1;
                scan_nxt  = 2'd0;
                state_nxt = ST_SCAN;
              end else begin
                state_nxt = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CUR: begin
        state_nxt = ST_EMIT;
        priority if (pos_r >= len_sel) begin
          tracking_nxt      = 1'b0;
          res_nxt.status    = STATUS_DONE;
          res_nxt.seq_index = cur_seq_r;
        end else if (tick_r >= timeout_r) begin
          tracking_nxt = 1'b0;
        end else if (!has_key_r) begin
          res_nxt.status = STATUS_PROGRESS;
        end else begin
          res_nxt.key_taken = 1'b1;
          if (key_r == sym_byte(row_sel, pos_r[2:0])) begin
            tick_nxt       = '0;
            pos_nxt        = pos_r + 4'd1;
            res_nxt.status = STATUS_PROGRESS;
          end else begin
            cur_row_nxt = row_sel;
            start_nxt   = 1'b0;
            scan_nxt    = 2'd0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        res_nxt.key_taken = 1'b1;
        if (hit) begin
          tracking_nxt   = 1'b1;
          cur_seq_nxt    = scan_r;
          res_nxt.status = STATUS_PROGRESS;
          state_nxt      = ST_EMIT;
          if (start_r) begin
            pos_nxt  = 4'd1;
            tick_nxt = '0;
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end else if (scan_r == SCAN_LAST) begin
          tracking_nxt = 1'b0;
          state_nxt    = ST_EMIT;
        end else begin
          scan_nxt = scan_r + 2'd1;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tracking_r  <= 1'b0;
      cur_seq_r   <= '0;
      pos_r       <= '0;
      tick_r      <= '0;
      start_r     <= 1'b0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tracking_r  <= tracking_nxt;
      cur_seq_r   <= cur_seq_nxt;
      pos_r       <= pos_nxt;
      tick_r      <= tick_nxt;
      start_r     <= start_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    has_key_r <= has_key_nxt;
    cur_row_r <= cur_row_nxt;
    res_r     <= res_nxt;
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_res_r.status;
  assign out_seq_index = out_res_r.seq_index;
  assign out_key_taken = out_res_r.key_taken;

endmodule

// ===== hdl/ksd_checker.sv =====
// ----------------------------------------------------------------------------
// ksd_checker
// Port-level checks for the key sequence detector, bound to the top level.
// ----------------------------------------------------------------------------
module ksd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input ksd_pkg::mode_t    in_mode,
  input logic              out_valid,
  input logic              out_stall,
  input ksd_pkg::status_t  out_status,
  input logic [1:0]        out_seq_index,
  input logic              out_key_taken
);
  import ksd_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_seq_index) && $stable(out_key_taken))
    else $error("stalled result changed");

  a_index_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_DONE) |-> out_seq_index == 2'd0)
    else $error("sequence index without completion");

  a_done_untaken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_DONE) |-> !out_key_taken)
    else $error("completion took the key");

  a_tick_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == MODE_TICK || in_mode == MODE_NONE) |=> !in_stall)
    else $error("tick transfer held the input");

endmodule

bind key_sequence_detector_top ksd_checker u_ksd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_mode       (in_mode),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_seq_index (out_seq_index),
  .out_key_taken (out_key_taken)
);

// ===== dv/ksd_match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_match_checker
// Follows register writes and input transfers of the key sequence detector,
// predicts the result of every poll and compares each output transfer, field
// by field, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module ksd_match_checker #(
  parameter int NUM_SEQS = 4,
  parameter int MAX_LEN  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  ksd_pkg::mode_t                in_mode,
  input  logic [7:0]                    in_key_code,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  ksd_pkg::status_t              out_status,
  input  logic [1:0]                    out_seq_index,
  input  logic                          out_key_taken,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic                          cfg_pready,
  input  logic [ksd_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  logic [ksd_pkg::DATA_BITS-1:0] cfg_pwdata,
  output int                            fail_count,
  output int                            awaited_count,
  output int                            results_seen,
  output int                            completions_seen
);
  import ksd_pkg::*;

  logic [ROW_BITS-1:0]  stored_syms [SEQ_SLOTS];
  logic [15:0]          stored_lens;
  logic [SEQ_SLOTS-1:0] stored_en;
  logic [15:0]          stored_timeout;
  bit                   tracking;
  int                   cur_seq;
  int                   position;
  logic [15:0]          tick_count;
  result_t              awaited_q [$];
  result_t              head;
  result_t              predicted;
  reg_idx_t             widx;
  int                   mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [7:0] sym_of(input int n, input int k);
    return stored_syms[n & 3][8 * (k & 7) +: 8];
  endfunction

  function automatic int len_of(input int n);
    int l;
    l = int'(stored_lens[4 * (n & 3) +: 4]);
    return (l > MAX_LEN) ? MAX_LEN : l;
  endfunction

  function automatic bit usable(input int n);
    return n < NUM_SEQS && n < SEQ_SLOTS && stored_en[n];
  endfunction

  function automatic bit predict_poll(input mode_t mode, input logic [7:0] key,
                                      output result_t res);
    bit found;
    bit same;
    res   = '0;
    found = 1'b0;
    if (mode == MODE_TICK) begin
      if (tick_count != TICK_MAX) tick_count++;
      return 1'b0;
    end
    if (mode == MODE_NONE) return 1'b0;
    if (!tracking) begin
      if (mode == MODE_POLL_KEY) begin
        res.key_taken = 1'b1;
        for (int n = 0; n < SEQ_SLOTS; n++) begin
          if (!usable(n) || len_of(n) == 0) continue;
          if (sym_of(n, 0) == key) begin
            tracking   = 1'b1;
            cur_seq    = n;
            position   = 1;
            tick_count = '0;
            res.status = STATUS_PROGRESS;
            break;
          end
        end
      end
    end else if (position >= len_of(cur_seq)) begin
      tracking      = 1'b0;
      res.status    = STATUS_DONE;
      res.seq_index = 2'(cur_seq);
    end else if (tick_count >= stored_timeout) begin
      tracking = 1'b0;
    end else if (mode == MODE_POLL) begin
      res.status = STATUS_PROGRESS;
    end else begin
      res.key_taken = 1'b1;
      if (key == sym_of(cur_seq, position)) begin
        tick_count = '0;
        position++;
        res.status = STATUS_PROGRESS;
      end else begin
        // try a sibling sequence sharing the prefix typed so far
        for (int n = 0; n < SEQ_SLOTS && !found; n++) begin
          if (!usable(n) || n == cur_seq || position + 1 > len_of(n)) continue;
          same = 1'b1;
          for (int j = 0; j < position; j++)
            if (sym_of(n, j) != sym_of(cur_seq, j)) same = 1'b0;
          if (same && sym_of(n, position) == key) begin
            cur_seq = n;
            position++;
            found = 1'b1;
          end
        end
        if (found) res.status = STATUS_PROGRESS;
        else tracking = 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < SEQ_SLOTS; n++) stored_syms[n] = '0;
      stored_lens      = '0;
      stored_en        = '0;
      stored_timeout   = TIMEOUT_RESET;
      tracking         = 1'b0;
      cur_seq          = 0;
      position         = 0;
      tick_count       = '0;
      results_seen     = 0;
      completions_seen = 0;
      awaited_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        widx = reg_idx_t'(cfg_paddr >> 3);
        case (widx)
          REG_SEQ0, REG_SEQ1, REG_SEQ2, REG_SEQ3: begin
            stored_syms[widx[1:0]] = cfg_pwdata[ROW_BITS-1:0];
          end
          REG_LENGTHS: stored_lens    = cfg_pwdata[15:0];
          REG_ENABLES: stored_en      = cfg_pwdata[SEQ_SLOTS-1:0];
          REG_TIMEOUT: stored_timeout = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("result status=%0d index=%0d taken=%0d with none awaited",
                                    out_status, out_seq_index, out_key_taken));
        end else begin
          head = awaited_q.pop_front();
          if (head.status == STATUS_DONE) completions_seen++;
          if (out_status !== head.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, head.status));
          if (out_seq_index !== head.seq_index)
            report_mismatch($sformatf("seq_index got %0d want %0d",
                                      out_seq_index, head.seq_index));
          if (out_key_taken !== head.key_taken)
            report_mismatch($sformatf("key_taken got %0d want %0d",
                                      out_key_taken, head.key_taken));
        end
      end
      if (in_valid && !in_stall) begin
        if (predict_poll(in_mode, in_key_code, predicted)) awaited_q.push_back(predicted);
      end
    end
    awaited_count <= awaited_q.size();
  end

endmodule

// ===== dv/tb_key_sequence_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_sequence_detector_top
// Drives the key sequence detector with directed and random key, poll and
// tick traffic under several register setups and idling patterns; the
// match checker predicts and compares every result, this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_key_sequence_detector_top;
  import ksd_pkg::*;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  mode_t                in_mode     = MODE_TICK;
  logic [7:0]           in_key_code = '0;
  logic                 out_stall   = 1'b0;
  logic                 cfg_psel    = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite  = 1'b0;
  logic [ADDR_BITS-1:0] cfg_paddr   = '0;
  logic [DATA_BITS-1:0] cfg_pwdata  = '0;

  logic                 in_stall;
  logic                 out_valid;
  status_t              out_status;
  logic [1:0]           out_seq_index;
  logic                 out_key_taken;
  logic [DATA_BITS-1:0] cfg_prdata;
  logic                 cfg_pready;

  int fail_count;
  int awaited_count;
  int results_seen;
  int completions_seen;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int setups_done   = 0;

  logic [63:0] cur_syms [4];
  logic [15:0] cur_lens;
  logic [3:0]  cur_en;
  logic [15:0] cur_timeout;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  key_sequence_detector_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_key_code   (in_key_code),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_seq_index (out_seq_index),
    .out_key_taken (out_key_taken),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  ksd_match_checker match_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_key_code      (in_key_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_seq_index    (out_seq_index),
    .out_key_taken    (out_key_taken),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_pready       (cfg_pready),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .fail_count       (fail_count),
    .awaited_count    (awaited_count),
    .results_seen     (results_seen),
    .completions_seen (completions_seen)
  );

  // hold off the output for a long stretch on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_served + 1;
      hold_left   <= 200;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [7:0] seq_sym(input int n, input int k);
    return cur_syms[n & 3][8 * (k & 7) +: 8];
  endfunction

  function automatic int seq_len(input int n);
    int l;
    l = int'(cur_lens[4 * (n & 3) +: 4]);
    return (l > 8) ? 8 : l;
  endfunction

  task automatic send_item(input mode_t m, input logic [7:0] k);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid    <= 1'b0;
      in_mode     <= mode_t'($urandom_range(3));
      in_key_code <= 8'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= m;
    in_key_code <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (m != MODE_NONE) items_sent++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_BITS'(idx) << 3;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_setup(input logic [63:0] s0, input logic [63:0] s1,
                             input logic [63:0] s2, input logic [63:0] s3,
                             input logic [15:0] lens, input logic [3:0] en,
                             input logic [15:0] tmo);
    cur_syms[0] = s0;
    cur_syms[1] = s1;
    cur_syms[2] = s2;
    cur_syms[3] = s3;
    cur_lens    = lens;
    cur_en      = en;
    cur_timeout = tmo;
    write_reg(REG_SEQ0, s0);
    write_reg(REG_SEQ1, s1);
    write_reg(REG_SEQ2, s2);
    write_reg(REG_SEQ3, s3);
    write_reg(REG_LENGTHS, {48'd0, lens});
    write_reg(REG_ENABLES, {60'd0, en});
    write_reg(REG_TIMEOUT, {48'd0, tmo});
    setups_done++;
  endtask

  // drain all awaited results, then let a trailing tick finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    int          n;
    int          k;
    int          pick;
    int          count;
    int          target;
    int          style;
    int          l;
    logic [63:0] base;
    logic [63:0] syms [4];
    logic [15:0] lens;
    logic [15:0] tmo;
    logic [3:0]  en;
    bit          narrow;
    logic [7:0]  b;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset setup: nothing enabled
    send_item(MODE_POLL, 8'h00);
    send_item(MODE_NONE, 8'hA5);
    send_item(MODE_POLL_KEY, 8'hFF);
    settle();

    // seq1 shares a two-symbol prefix with seq0 and has an oversized length,
    // seq2 is enabled but empty, seq3 is disabled
    write_setup(64'h44335AFF0024321C, 64'h9A7856341277321C, 64'h0000000000000099,
                64'h00000000000000FF, 16'h10F8, 4'b0111, 16'd3);
    send_item(MODE_POLL_KEY, 8'h99);
    send_item(MODE_POLL_KEY, 8'h1C);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_POLL, 8'h00);
    send_item(MODE_POLL_KEY, 8'h32);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_POLL_KEY, 8'h77);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_POLL, 8'h00);
    for (k = 0; k < 8; k++) send_item(MODE_POLL_KEY, seq_sym(0, k));
    send_item(MODE_POLL_KEY, 8'h10);
    send_item(MODE_POLL_KEY, 8'h1C);
    send_item(MODE_POLL_KEY, 8'h55);
    send_item(MODE_POLL_KEY, 8'h1C);
    settle();

    for (int regime = 0; regime < 3; regime++) begin
      send_idle_pct <= (regime == 0) ? 27 : (regime == 1) ? 69 : 0;
      recv_idle_pct <= (regime == 0) ? 69 : (regime == 1) ? 27 : 0;
      for (int sub = 0; sub < 5; sub++) begin
        style = $urandom_range(9);
        if (style == 0) begin
          write_setup('1, '1, '1, '1, 16'hFFFF, 4'hF, 16'hFFFF);
        end else if (style == 1) begin
          write_setup('0, '0, '0, '0, 16'h0000, 4'h0, 16'h0000);
        end else begin
          narrow = $urandom_range(1);
          base   = {$urandom, $urandom};
          if (narrow) base &= 64'h8181818181818181;
          for (n = 0; n < 4; n++) begin
            syms[n] = base;
            for (k = $urandom_range(8); k < 8; k++) begin
              b = 8'($urandom);
              syms[n][8 * k +: 8] = narrow ? (b & 8'h81) : b;
            end
            l = $urandom_range(10);
            lens[4 * n +: 4] = (l >= 9) ? 4'($urandom_range(9, 15)) : 4'(l);
          end
          en = ($urandom_range(9) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
          case ($urandom_range(5))
            0: tmo = 16'd0;
            1: tmo = 16'd1;
            2: tmo = 16'($urandom_range(2, 12));
            3: tmo = TIMEOUT_RESET;
            4: tmo = TICK_MAX;
            default: tmo = 16'($urandom_range(13, 400));
          endcase
          write_setup(syms[0], syms[1], syms[2], syms[3], lens, en, tmo);
        end
        if (sub == 0) hold_asked <= hold_asked + 1;
        target = items_sent + 100;
        while (items_sent < target) begin
          pick = $urandom_range(99);
          n    = $urandom_range(3);
          if (pick < 70) begin
            if (cur_en[n] && seq_len(n) != 0) begin
              for (k = 0; k < seq_len(n); k++) begin
                if ($urandom_range(3) == 0)
                  repeat ($urandom_range(1, 3)) send_item(MODE_TICK, 8'($urandom));
                if ($urandom_range(5) == 0) send_item(MODE_POLL, 8'($urandom));
                pick = $urandom_range(99);
                if (pick < 6) send_item(MODE_POLL_KEY, 8'($urandom));
                else if (pick < 14) send_item(MODE_POLL_KEY, seq_sym($urandom_range(3), k));
                else send_item(MODE_POLL_KEY, seq_sym(n, k));
              end
              if ($urandom_range(1)) send_item(MODE_POLL, 8'($urandom));
              else send_item(MODE_POLL_KEY, 8'($urandom));
            end else begin
              send_item(MODE_POLL_KEY, 8'($urandom));
            end
          end else if (pick < 85) begin
            send_item(MODE_POLL_KEY, seq_sym(n, 0));
            if (cur_timeout <= 40) count = int'(cur_timeout) - 1 + int'($urandom_range(2));
            else count = int'($urandom_range(5));
            if (count < 0) count = 0;
            repeat (count) send_item(MODE_TICK, 8'($urandom));
            if ($urandom_range(1)) send_item(MODE_POLL, 8'($urandom));
            else send_item(MODE_POLL_KEY, seq_sym(n, 1));
          end else begin
            repeat ($urandom_range(1, 6))
              send_item(mode_t'($urandom_range(3)), 8'($urandom));
          end
        end
        settle();
      end
    end

    // run the tick counter well past a short timeout, then restart
    write_setup(64'h0000000000003C2B, '0, '0, '0, 16'h0002, 4'h1, 16'd8);
    send_item(MODE_POLL_KEY, 8'h2B);
    repeat (20) send_item(MODE_TICK, 8'h00);
    send_item(MODE_POLL, 8'h00);
    send_item(MODE_POLL_KEY, 8'h2B);
    send_item(MODE_POLL, 8'h00);
    settle();

    $display("Checked %0d results (%0d completions) from %0d transfers in, %0d register setups.",
             results_seen, completions_seen, items_sent, setups_done);
    $display("Idling mixes 27/69, 69/27 and 0/0 percent, long output hold-offs, timeouts.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Run timed out waiting on the design.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ksd_pkg.sv
hdl/key_sequence_detector_top.sv
hdl/ksd_checker.sv
dv/ksd_match_checker.sv
dv/tb_key_sequence_detector_top.sv
